[rtl/esc_telemetry_poller_core_assert.svh]
// Assertion macros for the checker file of the telemetry poller.
// Each expects clk_i, and ETP_ASSERT also rst_ni, in the scope where used.
`ifndef ESC_TELEMETRY_POLLER_CORE_ASSERT_SVH
`define ESC_TELEMETRY_POLLER_CORE_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define ETP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ETP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/etp_pkg.sv]
// ----------------------------------------------------------------------------
// etp_pkg
// Types, constants and small functions of the telemetry poller.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

  localparam int MaxMotors = 8;
  localparam int MotorIdxW = $clog2(MaxMotors);
  localparam int FrameLen  = 10;
  localparam int FrameIdxW = $clog2(FrameLen);

  localparam logic [7:0] CrcPoly = 8'h07;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegMotorCount = 3'd0;
  localparam logic [2:0] RegBootDelay  = 3'd1;
  localparam logic [2:0] RegTimeout    = 3'd2;
  localparam logic [2:0] RegRetryLimit = 3'd3;
  localparam logic [2:0] RegSilence    = 3'd4;

  // Register reset values.
  localparam logic [3:0]  RstMotorCount = 4'd4;
  localparam logic [15:0] RstBootDelay  = 16'd5000;
  localparam logic [15:0] RstTimeout    = 16'd100;
  localparam logic [3:0]  RstRetryLimit = 4'd4;
  localparam logic [15:0] RstSilence    = 16'd10000;

  // Frame status codes.
  localparam logic [1:0] StatusNone     = 2'd0;
  localparam logic [1:0] StatusAccepted = 2'd1;
  localparam logic [1:0] StatusCrcBad   = 2'd2;

  typedef struct packed {
    logic                 byte_wr;
    logic                 tick_start;
    logic                 crc_step;
    logic                 time_step;
    logic                 frame_step;
    logic                 agg_step;
    logic                 agg_done;
    logic                 fin_step;
    logic [FrameIdxW-1:0] idx;
  } etp_cmd_t;

  typedef struct packed {
    logic agg_req;
  } etp_sts_t;

  typedef struct packed {
    logic                 active;
    logic                 request_valid;
    logic [2:0]           request_motor;
    logic [1:0]           frame_status;
    logic [7:0]           frame_temperature;
    logic signed [15:0]   frame_rpm;
    logic signed [15:0]   voltage_avg;
    logic signed [15:0]   current_sum;
    logic signed [15:0]   consumption_sum;
  } etp_result_t;

  // Motor count with zero read as one and large values clipped.
  function automatic logic [3:0] eff_count(logic [3:0] mc);
    logic [3:0] r;
    if (mc == 4'd0) begin
      r = 4'd1;
    end else if (mc > 4'(MaxMotors)) begin
      r = 4'(MaxMotors);
    end else begin
      r = mc;
    end
    return r;
  endfunction

  function automatic logic [MotorIdxW-1:0] next_motor(logic [MotorIdxW-1:0] mi,
                                                      logic [3:0] eff);
    logic [MotorIdxW:0] n;
    n = {1'b0, mi} + 1'b1;
    if (4'(n) >= eff) begin
      n = '0;
    end
    return n[MotorIdxW-1:0];
  endfunction

  // Eight shift steps of CRC-8 on a value that already holds the byte.
  function automatic logic [7:0] crc8_shift(logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/etp_if.sv]
// ----------------------------------------------------------------------------
// etp_in_if / etp_out_if
// Valid/ready channels of the telemetry poller.
// ----------------------------------------------------------------------------
`default_nettype none

interface etp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, opcode, rx_byte, now_ms, input ready);
  modport sink   (input valid, opcode, rx_byte, now_ms, output ready);
endinterface

interface etp_out_if;
  logic               valid;
  logic               ready;
  logic               active;
  logic               request_valid;
  logic [2:0]         request_motor;
  logic [1:0]         frame_status;
  logic [7:0]         frame_temperature;
  logic signed [15:0] frame_rpm;
  logic signed [15:0] voltage_avg;
  logic signed [15:0] current_sum;
  logic signed [15:0] consumption_sum;

  modport source (output valid, active, request_valid, request_motor, frame_status,
                  frame_temperature, frame_rpm, voltage_avg, current_sum,
                  consumption_sum, input ready);
  modport sink   (input valid, active, request_valid, request_motor, frame_status,
                  frame_temperature, frame_rpm, voltage_avg, current_sum,
                  consumption_sum, output ready);
endinterface

`default_nettype wire

[rtl/etp_ctrl.sv]
// ----------------------------------------------------------------------------
// etp_ctrl
// Sequencer: steps one tick through CRC, timing, frame, aggregation, finish.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_opcode_i,
  output logic                  in_ready_o,
  input  wire logic [3:0]       motor_count_i,
  input  wire etp_pkg::etp_sts_t sts_i,
  input  wire logic             out_free_i,
  output logic                  out_load_o,
  output etp_pkg::etp_cmd_t     cmd_o
);
  import etp_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StCrc, StTime, StFrame, StAgg, StFin, StHold
  } state_e;

  state_e               state_q, state_d;
  logic [FrameIdxW-1:0] cnt_q, cnt_d;
  logic [3:0]           eff;
  logic                 agg_last;

  assign eff      = eff_count(motor_count_i);
  assign agg_last = (4'(cnt_q) == (eff - 4'd1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_opcode_i) begin
            cmd_o.byte_wr = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
            cnt_d   = '0;
            state_d = StCrc;
          end
        end
      end
      StCrc: begin
        cmd_o.crc_step = 1'b1;
        if (cnt_q == FrameIdxW'(FrameLen - 2)) begin
          state_d = StTime;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StTime: begin
        cmd_o.time_step = 1'b1;
        state_d = StFrame;
      end
      StFrame: begin
        cmd_o.frame_step = 1'b1;
        cnt_d = '0;
        state_d = sts_i.agg_req ? StAgg : StFin;
      end
      StAgg: begin
        cmd_o.agg_step = 1'b1;
        if (agg_last) begin
          cmd_o.agg_done = 1'b1;
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        cmd_o.fin_step = 1'b1;
        state_d = StHold;
      end
      StHold: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/etp_dp.sv]
// ----------------------------------------------------------------------------
// etp_dp
// Datapath: frame buffer, CRC, polling state, per-motor store and totals.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire etp_pkg::etp_cmd_t cmd_i,
  output etp_pkg::etp_sts_t      sts_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [3:0]        motor_count_i,
  input  wire logic [15:0]       boot_delay_i,
  input  wire logic [15:0]       timeout_i,
  input  wire logic [3:0]        retry_limit_i,
  input  wire logic [15:0]       silence_i,
  output etp_pkg::etp_result_t   res_o
);
  import etp_pkg::*;

  typedef enum logic [1:0] {PhWait, PhReady, PhPending} phase_e;

  phase_e               phase_q, phase_d;
  logic                 running_q, running_d;
  logic [3:0]           bpos_q, bpos_d;
  logic                 rdy_q, rdy_d;
  logic [MotorIdxW-1:0] midx_q, midx_d;
  logic [3:0]           retry_q, retry_d;
  logic [31:0]          rstamp_q, rstamp_d;
  logic [31:0]          cstamp_q, cstamp_d;
  logic [31:0]          now_q;
  logic                 gate_q, gate_d;
  logic [7:0]           crc_q, crc_d;
  logic [15:0]          v_q, v_d, c_q, c_d, s_q, s_d;
  logic [15:0]          vtot_q, vtot_d, ctot_q, ctot_d, stot_q, stot_d;
  logic                 reqv_q, reqv_d;
  logic [2:0]           reqm_q, reqm_d;
  logic [1:0]           status_q, status_d;
  logic [7:0]           temp_q, temp_d;
  logic [15:0]          rpm_q, rpm_d;

  logic [7:0]           frame_q [FrameLen];
  logic                 skip_q  [MaxMotors];
  logic [15:0]          volt_q  [MaxMotors];
  logic [15:0]          cur_q   [MaxMotors];
  logic [15:0]          cons_q  [MaxMotors];

  logic                 byte_we;
  logic [FrameIdxW-1:0] byte_idx;
  logic                 skip_set;
  logic [MotorIdxW-1:0] skip_idx;
  logic                 store;
  logic [3:0]           eff;

  assign eff = eff_count(motor_count_i);

  always_comb begin
    logic [3:0]           pos;
    logic [31:0]          lim;
    logic [MotorIdxW-1:0] ai;
    logic [15:0]          sx, vb, cb, sb, vn, cn, sn;
    logic [16:0]          sum, adj;

    pos = '0; lim = '0; ai = '0; sx = '0; vb = '0; cb = '0; sb = '0;
    vn = '0; cn = '0; sn = '0; sum = '0; adj = '0;

    phase_d = phase_q;   running_d = running_q; bpos_d = bpos_q;
    rdy_d = rdy_q;       midx_d = midx_q;       retry_d = retry_q;
    rstamp_d = rstamp_q; cstamp_d = cstamp_q;   gate_d = gate_q;
    crc_d = crc_q;       v_d = v_q; c_d = c_q;  s_d = s_q;
    vtot_d = vtot_q;     ctot_d = ctot_q;       stot_d = stot_q;
    reqv_d = reqv_q;     reqm_d = reqm_q;       status_d = status_q;
    temp_d = temp_q;     rpm_d = rpm_q;
    byte_we = 1'b0; byte_idx = '0; skip_set = 1'b0; skip_idx = '0; store = 1'b0;
    sts_o = '0;

    // Bytes count only while polling runs; a full frame waits for a tick.
    if (cmd_i.byte_wr && running_q && (phase_q != PhWait)) begin
      pos = (bpos_q >= 4'(FrameLen)) ? 4'd0 : bpos_q;
      byte_we  = 1'b1;
      byte_idx = FrameIdxW'(pos);
      if (pos == 4'(FrameLen - 1)) begin
        rdy_d  = 1'b1;
        bpos_d = '0;
      end else begin
        bpos_d = pos + 4'd1;
      end
    end

    if (cmd_i.tick_start) begin
      gate_d   = running_q && (now_ms_i >= {16'd0, boot_delay_i});
      crc_d    = '0;
      reqv_d   = 1'b0;
      reqm_d   = '0;
      status_d = StatusNone;
      temp_d   = '0;
      rpm_d    = '0;
    end

    if (cmd_i.crc_step) begin
      crc_d = crc8_shift(crc_q ^ frame_q[cmd_i.idx]);
    end

    // Start of polling, request issue and the timeout/retry/skip path.
    if (cmd_i.time_step && gate_q) begin
      if (phase_q == PhWait) begin
        phase_d  = PhReady;
        midx_d   = '0;
        retry_d  = '0;
        rstamp_d = now_q;
        cstamp_d = now_q;
      end else if (phase_q == PhReady) begin
        reqv_d  = 1'b1;
        reqm_d  = 3'(midx_q);
        phase_d = PhPending;
      end
      lim = rstamp_d + {16'd0, timeout_i};
      if (lim < now_q) begin
        if (retry_d != 4'd15) begin
          retry_d = retry_d + 4'd1;
        end
        rstamp_d = now_q;
        phase_d  = PhReady;
        if (retry_d >= retry_limit_i) begin
          skip_set = 1'b1;
          skip_idx = midx_d;
          midx_d   = next_motor(midx_d, eff);
          retry_d  = '0;
          cstamp_d = now_q;
        end
      end
    end

    if (cmd_i.frame_step && gate_q && rdy_q) begin
      rdy_d = 1'b0;
      if (crc_q == frame_q[FrameLen-1]) begin
        store    = 1'b1;
        status_d = StatusAccepted;
        temp_d   = frame_q[0];
        rpm_d    = {frame_q[7], frame_q[8]};
        sts_o.agg_req = (4'(midx_q) == (eff - 4'd1));
        midx_d   = next_motor(midx_q, eff);
        retry_d  = '0;
        rstamp_d = now_q;
        cstamp_d = now_q;
        phase_d  = PhReady;
      end else begin
        status_d = StatusCrcBad;
      end
    end

    // One motor per step. Voltage is a running halved mean, truncated to zero.
    if (cmd_i.agg_step) begin
      ai = cmd_i.idx[MotorIdxW-1:0];
      sx = volt_q[ai];
      vb = (ai == '0) ? 16'd0 : v_q;
      cb = (ai == '0) ? 16'd0 : c_q;
      sb = (ai == '0) ? 16'd0 : s_q;
      sum = {vb[15], vb} + {sx[15], sx};
      adj = sum + {16'd0, sum[16]};
      if (skip_q[ai]) begin
        vn = vb; cn = cb; sn = sb;
      end else begin
        vn = (ai == '0) ? sx : adj[16:1];
        cn = cb + cur_q[ai];
        sn = sb + cons_q[ai];
      end
      v_d = vn; c_d = cn; s_d = sn;
      if (cmd_i.agg_done) begin
        vtot_d = vn; ctot_d = cn; stot_d = sn;
      end
    end

    if (cmd_i.fin_step && gate_q) begin
      lim = cstamp_q + {16'd0, silence_i};
      if (lim < now_q) begin
        running_d = 1'b0;
        vtot_d = '0; ctot_d = '0; stot_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhWait;
      running_q <= 1'b1;
      bpos_q    <= '0;
      rdy_q     <= 1'b0;
      midx_q    <= '0;
      retry_q   <= '0;
      rstamp_q  <= '1;
      cstamp_q  <= '1;
      gate_q    <= 1'b0;
      vtot_q    <= '0;
      ctot_q    <= '0;
      stot_q    <= '0;
      for (int i = 0; i < FrameLen; i++) begin
        frame_q[i] <= '0;
      end
      for (int i = 0; i < MaxMotors; i++) begin
        skip_q[i] <= 1'b0;
        volt_q[i] <= '0;
        cur_q[i]  <= '0;
        cons_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      running_q <= running_d;
      bpos_q    <= bpos_d;
      rdy_q     <= rdy_d;
      midx_q    <= midx_d;
      retry_q   <= retry_d;
      rstamp_q  <= rstamp_d;
      cstamp_q  <= cstamp_d;
      gate_q    <= gate_d;
      vtot_q    <= vtot_d;
      ctot_q    <= ctot_d;
      stot_q    <= stot_d;
      if (byte_we) begin
        frame_q[byte_idx] <= rx_byte_i;
      end
      if (skip_set) begin
        skip_q[skip_idx] <= 1'b1;
      end
      if (store) begin
        skip_q[midx_q] <= 1'b0;
        volt_q[midx_q] <= {frame_q[1], frame_q[2]};
        cur_q[midx_q]  <= {frame_q[3], frame_q[4]};
        cons_q[midx_q] <= {frame_q[5], frame_q[6]};
      end
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      now_q <= now_ms_i;
    end
    crc_q    <= crc_d;
    v_q      <= v_d;
    c_q      <= c_d;
    s_q      <= s_d;
    reqv_q   <= reqv_d;
    reqm_q   <= reqm_d;
    status_q <= status_d;
    temp_q   <= temp_d;
    rpm_q    <= rpm_d;
  end

  always_comb begin
    res_o.active            = running_q;
    res_o.request_valid     = reqv_q;
    res_o.request_motor     = reqm_q;
    res_o.frame_status      = status_q;
    res_o.frame_temperature = temp_q;
    res_o.frame_rpm         = rpm_q;
    res_o.voltage_avg       = vtot_q;
    res_o.current_sum       = ctot_q;
    res_o.consumption_sum   = stot_q;
  end

endmodule

`default_nettype wire

[rtl/esc_telemetry_poller_core.sv]
// ----------------------------------------------------------------------------
// esc_telemetry_poller_core
// Round-robin telemetry poller for motor controllers with CRC-8 frame check.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Carries
//   in_if     in         valid/ready     opcode, rx_byte, now_ms
//   out_if    out        valid/ready     one result per tick
//   APB       in         psel/penable    five configuration registers
//
// A byte transfer produces no result. A tick steps through CRC over the
// first nine frame bytes (one frame byte per cycle through a shared CRC
// stage), a timing step, a frame step, aggregation over eff_count motors when
// the last motor's frame is accepted (one motor per cycle), a finish step and
// the load of the output register.
// Reset is asynchronous and active low. A finished result waits until the
// output register is free, and the input is taken again once the result has
// been loaded there.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_telemetry_poller_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  etp_in_if.sink           in_if,
  etp_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import etp_pkg::*;

  // Configuration registers.
  logic [3:0]  motor_count_q;
  logic [15:0] boot_delay_q;
  logic [15:0] timeout_q;
  logic [3:0]  retry_limit_q;
  logic [15:0] silence_q;
  logic [2:0]  reg_idx;
  logic        cfg_we;

  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_count_q <= RstMotorCount;
      boot_delay_q  <= RstBootDelay;
      timeout_q     <= RstTimeout;
      retry_limit_q <= RstRetryLimit;
      silence_q     <= RstSilence;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegMotorCount: motor_count_q <= pwdata[3:0];
        RegBootDelay:  boot_delay_q  <= pwdata[15:0];
        RegTimeout:    timeout_q     <= pwdata[15:0];
        RegRetryLimit: retry_limit_q <= pwdata[3:0];
        RegSilence:    silence_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMotorCount: prdata = {28'd0, motor_count_q};
      RegBootDelay:  prdata = {16'd0, boot_delay_q};
      RegTimeout:    prdata = {16'd0, timeout_q};
      RegRetryLimit: prdata = {28'd0, retry_limit_q};
      RegSilence:    prdata = {16'd0, silence_q};
      default:       prdata = '0;
    endcase
  end

  // Sequencer and datapath.
  etp_cmd_t    cmd;
  etp_sts_t    sts;
  etp_result_t res;
  logic        out_load;
  logic        out_free;

  etp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_opcode_i   (in_if.opcode),
    .in_ready_o    (in_if.ready),
    .motor_count_i (motor_count_q),
    .sts_i         (sts),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .cmd_o         (cmd)
  );

  etp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (in_if.rx_byte),
    .now_ms_i      (in_if.now_ms),
    .motor_count_i (motor_count_q),
    .boot_delay_i  (boot_delay_q),
    .timeout_i     (timeout_q),
    .retry_limit_i (retry_limit_q),
    .silence_i     (silence_q),
    .res_o         (res)
  );

  // Output register: holds a finished result until its transfer completes.
  logic        out_valid_q;
  etp_result_t out_q;

  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.active            = out_q.active;
  assign out_if.request_valid     = out_q.request_valid;
  assign out_if.request_motor     = out_q.request_motor;
  assign out_if.frame_status      = out_q.frame_status;
  assign out_if.frame_temperature = out_q.frame_temperature;
  assign out_if.frame_rpm         = out_q.frame_rpm;
  assign out_if.voltage_avg       = out_q.voltage_avg;
  assign out_if.current_sum       = out_q.current_sum;
  assign out_if.consumption_sum   = out_q.consumption_sum;

endmodule

`default_nettype wire

[rtl/etp_checker.sv]
// ----------------------------------------------------------------------------
// etp_checker
// Port-level assertions on the result channel of the telemetry poller.
// ----------------------------------------------------------------------------
`default_nettype none
`include "esc_telemetry_poller_core_assert.svh"

module etp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               active_i,
  input wire logic               request_valid_i,
  input wire logic [2:0]         request_motor_i,
  input wire logic [1:0]         frame_status_i,
  input wire logic signed [15:0] voltage_avg_i,
  input wire logic signed [15:0] current_sum_i,
  input wire logic signed [15:0] consumption_sum_i
);
  import etp_pkg::*;

  `ETP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_status_i) && $stable(voltage_avg_i), "result dropped or changed while stalled")
  // The tick that shuts the poller down may still carry a request or a frame.
  `ETP_ASSERT(a_off_zero, out_valid_i && !active_i |-> (voltage_avg_i == 16'sd0) && (current_sum_i == 16'sd0) && (consumption_sum_i == 16'sd0), "shut-down totals not cleared")
  `ETP_ASSERT(a_status_code, out_valid_i |-> (frame_status_i == StatusNone) || (frame_status_i == StatusAccepted) || (frame_status_i == StatusCrcBad), "unknown frame status")
  `ETP_ASSERT(a_req_motor, out_valid_i && !request_valid_i |-> request_motor_i == 3'd0, "motor index without request")
  `ETP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i, "result offered during reset")

endmodule

bind esc_telemetry_poller_core etp_checker u_etp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .active_i          (out_if.active),
  .request_valid_i   (out_if.request_valid),
  .request_motor_i   (out_if.request_motor),
  .frame_status_i    (out_if.frame_status),
  .voltage_avg_i     (out_if.voltage_avg),
  .current_sum_i     (out_if.current_sum),
  .consumption_sum_i (out_if.consumption_sum)
);

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telemetry poller core.
// ----------------------------------------------------------------------------
// Byte and tick transfers go into the input channel. A scoreboard keeps its own
// model of the poller and predicts one result for every accepted tick. Each
// result transfer is checked against the oldest prediction. The run walks
// through several register settings, including the extremes. The sender and
// receiver idle or stall at rates that vary between settings. Most of the
// random traffic is well-formed reply frames followed by ticks. The rest is
// timeouts, frames with a bad CRC, cut-off frames and stray bytes. The last
// setting drives the poller into shutdown.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import etp_pkg::*;

  localparam bit OpByte = 1'b0;
  localparam bit OpTick = 1'b1;

  // Long enough to cover any tick work still in flight.
  localparam int SettleCycles = 40;

  typedef enum int {PhWait, PhReady, PhPending} poll_phase_e;
  typedef bit [7:0] frame_t [FrameLen];

  // CRC-8 with polynomial 0x07 and initial value 0 over the first nine bytes.
  function automatic bit [7:0] frame_crc(frame_t f);
    bit [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < FrameLen - 1; i++) begin
      crc ^= f[i];
      for (int b = 0; b < 8; b++) begin
        crc = crc[7] ? ({crc[6:0], 1'b0} ^ 8'h07) : {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // Holds a model of the poller and the tick results that are still expected.
  class poller_scoreboard;
    bit [3:0]    motor_count;
    bit [15:0]   boot_delay;
    bit [15:0]   req_timeout;
    bit [3:0]    retry_limit;
    bit [15:0]   silence_limit;
    poll_phase_e phase;
    int unsigned byte_pos;
    frame_t      frame;
    bit          frame_ready;
    int unsigned motor_idx;
    int unsigned retries;
    bit [31:0]   req_stamp;
    bit [31:0]   change_stamp;
    bit          running;
    bit          skipped [MaxMotors];
    bit [15:0]   volt [MaxMotors];
    bit [15:0]   curr [MaxMotors];
    bit [15:0]   cons [MaxMotors];
    bit [15:0]   volt_total;
    bit [15:0]   curr_total;
    bit [15:0]   cons_total;
    etp_result_t tick_results_q[$];
    int          errors;

    function new();
      motor_count   = RstMotorCount;
      boot_delay    = RstBootDelay;
      req_timeout   = RstTimeout;
      retry_limit   = RstRetryLimit;
      silence_limit = RstSilence;
      phase         = PhWait;
      byte_pos      = 0;
      foreach (frame[i]) frame[i] = 8'h00;
      frame_ready   = 1'b0;
      motor_idx     = 0;
      retries       = 0;
      req_stamp     = '1;
      change_stamp  = '1;
      running       = 1'b1;
      for (int i = 0; i < MaxMotors; i++) begin
        skipped[i] = 1'b0;
        volt[i]    = '0;
        curr[i]    = '0;
        cons[i]    = '0;
      end
      volt_total = '0;
      curr_total = '0;
      cons_total = '0;
      errors     = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [31:0] value);
      case (idx)
        RegMotorCount: motor_count   = value[3:0];
        RegBootDelay:  boot_delay    = value[15:0];
        RegTimeout:    req_timeout   = value[15:0];
        RegRetryLimit: retry_limit   = value[3:0];
        RegSilence:    silence_limit = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned polled_motors();
      if (motor_count == 0) return 1;
      if (motor_count > MaxMotors) return MaxMotors;
      return motor_count;
    endfunction

    function bit takes_bytes();
      return running && phase != PhWait;
    endfunction

    function int unsigned pending();
      return tick_results_q.size();
    endfunction

    // The voltage is halved per motor after the first; int division truncates
    // toward zero as the block does.
    function void aggregate();
      int          v;
      bit [15:0]   c;
      bit [15:0]   q;
      v = 0;
      c = '0;
      q = '0;
      for (int unsigned i = 0; i < polled_motors(); i++) begin
        if (!skipped[i]) begin
          v = (i > 0) ? (v + int'($signed(volt[i]))) / 2 : int'($signed(volt[i]));
          c = c + curr[i];
          q = q + cons[i];
        end
      end
      volt_total = v[15:0];
      curr_total = c;
      cons_total = q;
    endfunction

    function void advance_motor(bit [31:0] now);
      motor_idx++;
      if (motor_idx >= polled_motors()) motor_idx = 0;
      retries      = 0;
      req_stamp    = now;
      change_stamp = now;
    endfunction

    function void note_input(bit op, bit [7:0] rx, bit [31:0] now);
      etp_result_t r;
      int unsigned m;
      r = '0;
      if (op == OpByte) begin
        if (!takes_bytes()) return;
        if (byte_pos >= FrameLen) byte_pos = 0;
        frame[byte_pos] = rx;
        if (byte_pos == FrameLen - 1) begin
          frame_ready = 1'b1;
          byte_pos    = 0;
        end else begin
          byte_pos++;
        end
        return;
      end
      if (running && now >= {16'h0000, boot_delay}) begin
        if (phase == PhWait) begin
          phase        = PhReady;
          motor_idx    = 0;
          retries      = 0;
          req_stamp    = now;
          change_stamp = now;
        end else if (phase == PhReady) begin
          r.request_valid = 1'b1;
          r.request_motor = motor_idx[2:0];
          phase = PhPending;
        end
        if (motor_idx >= MaxMotors) motor_idx = 0;
        // Stamp plus limit wraps at 32 bits before the compare.
        if (req_stamp + {16'h0000, req_timeout} < now) begin
          if (retries < 15) retries++;
          req_stamp = now;
          phase = PhReady;
          if (retries >= retry_limit) begin
            skipped[motor_idx] = 1'b1;
            advance_motor(now);
          end
        end
        if (frame_ready) begin
          frame_ready = 1'b0;
          if (frame_crc(frame) == frame[FrameLen-1]) begin
            m = motor_idx;
            skipped[m] = 1'b0;
            volt[m] = {frame[1], frame[2]};
            curr[m] = {frame[3], frame[4]};
            cons[m] = {frame[5], frame[6]};
            r.frame_status      = StatusAccepted;
            r.frame_temperature = frame[0];
            r.frame_rpm         = {frame[7], frame[8]};
            if (motor_idx == polled_motors() - 1) aggregate();
            advance_motor(now);
            phase = PhReady;
          end else begin
            r.frame_status = StatusCrcBad;
          end
        end
        if (change_stamp + {16'h0000, silence_limit} < now) begin
          running    = 1'b0;
          volt_total = '0;
          curr_total = '0;
          cons_total = '0;
        end
      end
      r.active          = running;
      r.voltage_avg     = volt_total;
      r.current_sum     = curr_total;
      r.consumption_sum = cons_total;
      tick_results_q.push_back(r);
    endfunction

    function void compare_field(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(etp_result_t act);
      etp_result_t exp_r;
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $realtime, act);
        errors++;
        return;
      end
      exp_r = tick_results_q.pop_front();
      compare_field("active", exp_r.active, act.active);
      compare_field("request_valid", exp_r.request_valid, act.request_valid);
      compare_field("request_motor", exp_r.request_motor, act.request_motor);
      compare_field("frame_status", exp_r.frame_status, act.frame_status);
      compare_field("frame_temperature", exp_r.frame_temperature, act.frame_temperature);
      compare_field("frame_rpm", exp_r.frame_rpm, act.frame_rpm);
      compare_field("voltage_avg", exp_r.voltage_avg, act.voltage_avg);
      compare_field("current_sum", exp_r.current_sum, act.current_sum);
      compare_field("consumption_sum", exp_r.consumption_sum, act.consumption_sum);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  etp_in_if  in_ch ();
  etp_out_if out_ch ();

  esc_telemetry_poller_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  poller_scoreboard sb = new();

  // Idle rates in percent for the current phase, and the length of a forced
  // receiver hold-off that the receiver process counts down by itself.
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        recv_hold_cycles = 0;
  int        items_sent = 0;
  bit [31:0] now_ms = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: check every result transfer, then decide on ready for the
  // next cycle. A pending hold-off wins over the random stall.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{active:            out_ch.active,
                          request_valid:     out_ch.request_valid,
                          request_motor:     out_ch.request_motor,
                          frame_status:      out_ch.frame_status,
                          frame_temperature: out_ch.frame_temperature,
                          frame_rpm:         out_ch.frame_rpm,
                          voltage_avg:       out_ch.voltage_avg,
                          current_sum:       out_ch.current_sum,
                          consumption_sum:   out_ch.consumption_sum});
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one item and returns once the transfer has happened. The random
  // gap comes first, so valid is never dropped and raised in one step.
  task automatic send_item(bit op, bit [7:0] rx, bit [31:0] now);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= rx;
    in_ch.now_ms  <= now;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(op, rx, now);
    items_sent++;
  endtask

  task automatic send_tick(int unsigned step_ms);
    now_ms = now_ms + step_ms;
    send_item(OpTick, 8'h00, now_ms);
  endtask

  task automatic send_frame(frame_t f);
    for (int i = 0; i < FrameLen; i++) send_item(OpByte, f[i], 32'h0);
  endtask

  // Random frame content; a bad frame gets a CRC byte that cannot match.
  task automatic send_random_frame(bit good);
    frame_t f;
    foreach (f[i]) f[i] = 8'($urandom);
    f[FrameLen-1] = frame_crc(f);
    if (!good) f[FrameLen-1] ^= 8'($urandom_range(1, 255));
    send_frame(f);
  endtask

  // Brings the byte counter back to a frame boundary with random filler.
  task automatic realign_frame();
    while (sb.takes_bytes() && sb.byte_pos != 0) send_item(OpByte, 8'($urandom), 32'h0);
  endtask

  task automatic reg_write(bit [2:0] idx, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // The sender stops until every predicted result has been taken, then lets
  // any byte-only work in the block finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(bit [3:0] mc, bit [15:0] boot, bit [15:0] tmo,
                           bit [3:0] rl, bit [15:0] sil);
    drain();
    reg_write(RegMotorCount, 32'(mc));
    reg_write(RegBootDelay, 32'(boot));
    reg_write(RegTimeout, 32'(tmo));
    reg_write(RegRetryLimit, 32'(rl));
    reg_write(RegSilence, 32'(sil));
  endtask

  // One random round. Well-formed frames followed by a tick dominate, so the
  // poller keeps moving through its motors.
  task automatic random_round();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_random_frame(1'b1);
      send_tick($urandom_range(1, 300));
    end else if (pick < 70) begin
      // Plain ticks, often long enough to time out and retry or skip.
      send_tick($urandom_range(0, 400));
    end else if (pick < 80) begin
      send_random_frame(1'b0);
      send_tick($urandom_range(1, 300));
    end else if (pick < 90) begin
      // A frame cut short, with a tick falling in the middle of it.
      cut = $urandom_range(1, FrameLen - 1);
      for (int i = 0; i < cut; i++) send_item(OpByte, 8'($urandom), 32'h0);
      send_tick($urandom_range(1, 200));
      realign_frame();
      send_tick($urandom_range(1, 200));
    end else begin
      for (int i = 0; i < $urandom_range(1, 3); i++) send_item(OpByte, 8'($urandom), 32'h0);
      realign_frame();
    end
  endtask

  task automatic random_phase(int idle_mode, int unsigned n_items);
    int unsigned stop_at;
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) random_round();
  endtask

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    frame_t f;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OpByte;
    in_ch.rx_byte <= '0;
    in_ch.now_ms  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: two motors, short boot delay and timeout.
    configure(4'd2, 16'd200, 16'd50, 4'd2, 16'd65535);
    send_item(OpByte, 8'hFF, 32'h0);   // ignored while waiting for boot
    send_tick(0);                      // before the boot delay
    send_tick(200);                    // boot delay reached, polling starts
    send_tick(10);                     // request to motor 0
    // Extreme field values: temperature 0, most positive voltage,
    // most negative current and rpm, all-ones consumption.
    f = '{8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00};
    f[FrameLen-1] = frame_crc(f);
    send_frame(f);
    send_tick(10);
    // Second motor closes the round and triggers aggregation.
    f = '{8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'h7F, 8'hFF, 8'h00};
    f[FrameLen-1] = frame_crc(f);
    send_frame(f);
    send_tick(10);
    send_tick(60);                     // timeout and retry
    send_tick(60);                     // second timeout skips the motor

    // Phase with the receiver held off for a long stretch: the output register
    // fills and the block stalls its input while the sender keeps offering.
    configure(4'd4, 16'd0, 16'd100, 4'd4, 16'd65535);
    recv_hold_cycles = 400;
    random_phase(0, 80);
    drain();
    random_phase(0, 80);

    configure(4'd8, 16'd0, 16'd1, 4'd1, 16'd65535);
    random_phase(1, 180);
    configure(4'd0, 16'd0, 16'd65535, 4'd15, 16'd65535);
    random_phase(2, 180);
    configure(4'd15, 16'd0, 16'd200, 4'd0, 16'd65535);
    random_phase(3, 180);
    configure(4'd1, 16'd0, 16'd30, 4'd3, 16'd60000);
    random_phase(0, 180);
    configure(4'd3, 16'd0, 16'd150, 4'd2, 16'd65535);
    random_phase(1, 180);
    // Largest boot delay: ticks below it do nothing beyond reporting totals.
    configure(4'd5, 16'd65535, 16'd80, 4'd5, 16'd65535);
    random_phase(3, 120);

    // A silence limit of one drives the poller into shutdown; after that bytes
    // are ignored and ticks report inactive with zero totals.
    configure(4'd5, 16'd0, 16'd80, 4'd5, 16'd1);
    send_tick(5);
    send_item(OpByte, 8'hA5, 32'h0);
    send_item(OpTick, 8'h00, 32'hFFFF_FFFF);
    send_item(OpTick, 8'h00, 32'h0000_0000);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
